// ===== hw/rtl/spm_pkg.sv =====
// Shared constants, types and codes for the signature profile matcher.
package spm_pkg;

  localparam int MAX_SIGS      = 64;
  localparam int MAX_BODY      = 32;
  localparam int MAX_PROFILES  = 32;
  localparam int PROFILE_SLOTS = 8;

  localparam int HIST_LEN   = MAX_BODY + 2;
  localparam int HIST_AW    = $clog2(HIST_LEN);
  localparam int SIG_AW     = $clog2(MAX_SIGS);
  localparam int PROF_AW    = $clog2(MAX_PROFILES);
  localparam int BODY_AW    = $clog2(MAX_BODY);
  localparam int SLOT_AW    = $clog2(PROFILE_SLOTS);
  localparam int LEN_W      = $clog2(MAX_BODY + 1);
  localparam int PLEN_W     = $clog2(PROFILE_SLOTS + 1);
  localparam int SIG_CNT_W  = 7;
  localparam int PROF_CNT_W = 6;
  localparam int LIMIT_W    = 18;
  localparam int MEMBER_W   = 6;

  localparam logic [LIMIT_W-1:0] DEFAULT_SCAN_LIMIT = LIMIT_W'(256000);

  typedef logic [7:0] byte_t;
  typedef byte_t [MAX_BODY-1:0] body_row_t;
  typedef logic [MEMBER_W-1:0] member_t;
  typedef member_t [PROFILE_SLOTS-1:0] member_row_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIG,
    ST_PROF,
    ST_PUT
  } state_t;

  localparam logic [2:0] REQ_LOAD_SIG  = 3'd0;
  localparam logic [2:0] REQ_LOAD_PROF = 3'd1;
  localparam logic [2:0] REQ_START     = 3'd2;
  localparam logic [2:0] REQ_BYTE      = 3'd3;
  localparam logic [2:0] REQ_EOF       = 3'd4;

  localparam logic [1:0] CFG_SIG_COUNT  = 2'd0;
  localparam logic [1:0] CFG_PROF_COUNT = 2'd1;
  localparam logic [1:0] CFG_SCAN_LIMIT = 2'd2;

  localparam logic [1:0] VERDICT_NONE  = 2'd0;
  localparam logic [1:0] VERDICT_CLEAN = 2'd1;
  localparam logic [1:0] VERDICT_MATCH = 2'd2;

endpackage

// ===== hw/rtl/spm_cell.sv =====
// One history cell: holds one folded byte and checks it against the signature under test.
module spm_cell (
  input  logic                       clk,
  input  spm_pkg::cell_ctl_t         ctl,
  input  logic [spm_pkg::HIST_AW-1:0] cell_pos,
  input  spm_pkg::byte_t             shift_in,
  input  logic [spm_pkg::LEN_W-1:0]  sig_len,
  input  logic [15:0]                sig_first,
  input  spm_pkg::body_row_t         sig_body,
  output spm_pkg::byte_t             hist,
  output logic                       match
);
  import spm_pkg::*;

  logic [HIST_AW-1:0] diff;
  logic [BODY_AW-1:0] body_idx;
  logic [HIST_AW:0]   pos_x;
  logic [HIST_AW:0]   len_x;
  byte_t              expected;
  logic               care;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      hist <= '0;
    end else if (ctl.shift) begin
      hist <= shift_in;
    end
  end

  // Body byte k sits at history position len-1-k; the first word follows it.
  always_comb begin
    pos_x    = {1'b0, cell_pos};
    len_x    = (HIST_AW + 1)'(sig_len);
    diff     = HIST_AW'(sig_len) - HIST_AW'(1) - cell_pos;
    body_idx = diff[BODY_AW-1:0];
    care     = 1'b1;
    if (pos_x < len_x) begin
      expected = sig_body[body_idx] - 8'd1;
    end else if (pos_x == len_x) begin
      expected = sig_first[15:8];
    end else if (pos_x == len_x + (HIST_AW + 1)'(1)) begin
      expected = sig_first[7:0];
    end else begin
      expected = '0;
      care     = 1'b0;
    end
    match = !care || (hist == expected);
  end

endmodule

// ===== hw/rtl/signature_profile_matcher.sv =====
// Top level of the signature profile matcher: tables, sequencer and the row of history cells.
//
// A load, start-of-file or ignored byte transaction starts no sweep. A scanned file byte
// sweeps the signatures in use: the signature table is read one entry per cycle and
// each entry is checked by the row of history cells; it stops early at a clean signature
// hit. End of file sweeps the profiles in use, one profile table read per cycle, and stops
// early at the first matching profile; after a clean hit it skips that sweep. No further
// input is taken during these sweeps; a finished verdict waits in the output register
// while new transactions are taken. There is no clearing pass after reset.
module signature_profile_matcher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [spm_pkg::LIMIT_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    req_type,
  input  logic [5:0]                    entry_index,
  input  logic [5:0]                    position,
  input  logic [15:0]                   word_value,
  input  logic [7:0]                    data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    verdict,
  output logic [15:0]                   threat_id
);
  import spm_pkg::*;

  logic [SIG_CNT_W-1:0]  sig_count;
  logic [PROF_CNT_W-1:0] profile_count;
  logic [LIMIT_W-1:0]    scan_limit;
  logic [SIG_CNT_W-1:0]  n_sigs;
  logic [PROF_CNT_W-1:0] n_profs;

  logic [15:0]      sig_first_mem [MAX_SIGS];
  logic [LEN_W-1:0] sig_len_mem   [MAX_SIGS];
  logic             sig_clean_mem [MAX_SIGS];
  body_row_t        sig_body_mem  [MAX_SIGS];
  logic [15:0]      prof_id_mem   [MAX_PROFILES];
  logic [PLEN_W-1:0] prof_len_mem [MAX_PROFILES];
  member_row_t      prof_mem_mem  [MAX_PROFILES];

  logic [15:0]       first_q;
  logic [LEN_W-1:0]  len_q;
  logic              clean_q;
  body_row_t         body_q;
  logic [15:0]       pid_q;
  logic [PLEN_W-1:0] plen_q;
  member_row_t       members_q;

  state_t state, state_next;
  logic [SIG_AW:0]   idx;
  logic [SIG_AW-1:0] rd_addr;
  logic              rd_pend;
  logic              issue;
  logic [SIG_AW:0]   idx_limit;

  logic [MAX_SIGS-1:0] seen;
  logic [LIMIT_W-1:0]  bytes_seen;
  logic                aborted;
  logic [1:0]          res_verdict;
  logic [15:0]         res_id;

  logic      accept;
  logic      out_free;
  logic      scan_ok;
  logic      sig_hit;
  logic      prof_hit;
  cell_ctl_t ctl;
  byte_t     folded;
  byte_t     hist  [HIST_LEN];
  logic [HIST_LEN-1:0] cell_match;

  logic [5:0] body_off;
  logic [5:0] slot_off;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign scan_ok  = !aborted && (bytes_seen < scan_limit);
  assign n_sigs   = (sig_count > SIG_CNT_W'(MAX_SIGS)) ? SIG_CNT_W'(MAX_SIGS) : sig_count;
  assign n_profs  = (profile_count > PROF_CNT_W'(MAX_PROFILES)) ?
                    PROF_CNT_W'(MAX_PROFILES) : profile_count;
  assign body_off = position - 6'd3;
  assign slot_off = position - 6'd2;
  assign folded   = (data_byte >= 8'h61 && data_byte <= 8'h7a) ? data_byte - 8'h20 : data_byte;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sig_count     <= '0;
      profile_count <= '0;
      scan_limit    <= DEFAULT_SCAN_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIG_COUNT:  sig_count     <= cfg_data[SIG_CNT_W-1:0];
        CFG_PROF_COUNT: profile_count <= cfg_data[PROF_CNT_W-1:0];
        CFG_SCAN_LIMIT: scan_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Signature table writes and registered reads.
  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_LOAD_SIG && 32'(entry_index) < MAX_SIGS) begin
      if (position == 6'd0) begin
        sig_first_mem[entry_index[SIG_AW-1:0]] <= word_value;
      end else if (position == 6'd1) begin
        sig_len_mem[entry_index[SIG_AW-1:0]] <= (word_value[5:0] > 6'(MAX_BODY)) ?
                                                LEN_W'(MAX_BODY) : LEN_W'(word_value[5:0]);
      end else if (position == 6'd2) begin
        sig_clean_mem[entry_index[SIG_AW-1:0]] <= word_value[0];
      end else if (32'(body_off) < MAX_BODY) begin
        sig_body_mem[entry_index[SIG_AW-1:0]][body_off[BODY_AW-1:0]] <= word_value[7:0];
      end
    end
    if (issue) begin
      first_q <= sig_first_mem[idx[SIG_AW-1:0]];
      len_q   <= sig_len_mem[idx[SIG_AW-1:0]];
      clean_q <= sig_clean_mem[idx[SIG_AW-1:0]];
      body_q  <= sig_body_mem[idx[SIG_AW-1:0]];
    end
  end

  // Profile table writes and registered reads.
  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_LOAD_PROF && 32'(entry_index) < MAX_PROFILES) begin
      if (position == 6'd0) begin
        prof_id_mem[entry_index[PROF_AW-1:0]] <= word_value;
      end else if (position == 6'd1) begin
        prof_len_mem[entry_index[PROF_AW-1:0]] <=
          (word_value[3:0] > 4'(PROFILE_SLOTS)) ? PLEN_W'(PROFILE_SLOTS) : PLEN_W'(word_value[3:0]);
      end else if (position >= 6'd2 && 32'(slot_off) < PROFILE_SLOTS) begin
        prof_mem_mem[entry_index[PROF_AW-1:0]][slot_off[SLOT_AW-1:0]] <= word_value[5:0];
      end
    end
    if (issue) begin
      pid_q     <= prof_id_mem[idx[PROF_AW-1:0]];
      plen_q    <= prof_len_mem[idx[PROF_AW-1:0]];
      members_q <= prof_mem_mem[idx[PROF_AW-1:0]];
    end
  end

  // Row of history cells.
  assign ctl.clear = rst || (accept && req_type == REQ_START);
  assign ctl.shift = accept && req_type == REQ_BYTE && scan_ok;

  for (genvar j = 0; j < HIST_LEN; j++) begin : g_cell
    spm_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cell_pos  (HIST_AW'(j)),
      .shift_in  ((j == 0) ? folded : hist[(j == 0) ? 0 : j - 1]),
      .sig_len   (len_q),
      .sig_first (first_q),
      .sig_body  (body_q),
      .hist      (hist[j]),
      .match     (cell_match[j])
    );
  end

  assign sig_hit = rd_pend && (&cell_match) &&
                   (bytes_seen >= LIMIT_W'(len_q) + LIMIT_W'(2));

  always_comb begin
    prof_hit = rd_pend;
    for (int j = 0; j < PROFILE_SLOTS; j++) begin
      if (PLEN_W'(j) < plen_q) begin
        if (!(32'(members_q[j]) < MAX_SIGS && seen[members_q[j]])) begin
          prof_hit = 1'b0;
        end
      end
    end
  end

  // Sequencer next state. The sweep ends in the cycle that checks the last entry read.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req_type == REQ_BYTE && scan_ok) begin
          state_next = ST_SIG;
        end else if (accept && req_type == REQ_EOF) begin
          state_next = aborted ? ST_PUT : ST_PROF;
        end
      end
      ST_SIG: begin
        if ((sig_hit && clean_q) || idx == idx_limit) begin
          state_next = ST_IDLE;
        end
      end
      ST_PROF: begin
        if (prof_hit || idx == idx_limit) begin
          state_next = ST_PUT;
        end
      end
      ST_PUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = 1'b1;
    idx_limit = '0;
    issue     = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_SIG: begin
        idx_limit = (SIG_AW + 1)'(n_sigs);
        issue     = idx < idx_limit;
      end
      ST_PROF: begin
        idx_limit = (SIG_AW + 1)'(n_profs);
        issue     = idx < idx_limit;
      end
      ST_PUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= idx[SIG_AW-1:0];
    if (state == ST_IDLE) begin
      idx <= '0;
    end else if (issue) begin
      idx <= idx + (SIG_AW + 1)'(1);
    end
  end

  // Scan state.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      seen       <= '0;
      bytes_seen <= '0;
      aborted    <= 1'b0;
    end else begin
      if (ctl.shift) begin
        bytes_seen <= bytes_seen + LIMIT_W'(1);
      end
      if (state == ST_SIG && sig_hit) begin
        if (clean_q) begin
          aborted <= 1'b1;
        end else begin
          seen[rd_addr] <= 1'b1;
        end
      end
    end
  end

  // Verdict under construction, then the output register.
  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_EOF) begin
      res_verdict <= aborted ? VERDICT_CLEAN : VERDICT_NONE;
      res_id      <= '0;
    end else if (state == ST_PROF && prof_hit) begin
      res_verdict <= VERDICT_MATCH;
      res_id      <= pid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_PUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PUT && out_free) begin
      verdict   <= res_verdict;
      threat_id <= res_id;
    end
  end

endmodule

// ===== hw/rtl/spm_checker.sv =====
// Port-level checks for the signature profile matcher, bound to the top level.
module spm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  req_type,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  verdict,
  input logic [15:0] threat_id
);
  import spm_pkg::*;

  // A waiting verdict holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(threat_id))
    else $error("verdict changed while stalled");

  // Only a profile match carries an id.
  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != VERDICT_MATCH |-> threat_id == 16'd0)
    else $error("nonzero id without profile match");

  // A transaction other than end of file never produces a verdict next cycle.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type != REQ_EOF && !out_valid |=> !out_valid)
    else $error("verdict without end of file");

  // Reset leaves the block idle with no verdict waiting.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind signature_profile_matcher spm_checker u_spm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .req_type  (req_type),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .verdict   (verdict),
  .threat_id (threat_id)
);
